// ===== rtl/core/ibeg_pkg.sv =====
// ----------------------------------------------------------------------------
// ibeg_pkg: shared types and codes for the instruction boundary gate
// Beat structs, action, exception and program-reason codes, instruction
// classes, register indexes, MSR, event, gate and perf-control bit positions.
// ----------------------------------------------------------------------------
package ibeg_pkg;

    typedef struct packed {
        logic [31:0] insn_addr;
        logic [6:0]  msr_bits;
        logic [3:0]  irq_events;
        logic        fetch_fault;
        logic        insn_known;
        logic [3:0]  insn_gates;
        logic        handler_present;
        logic [1:0]  insn_class;
        logic [31:0] next_addr;
        logic        handler_raised;
    } ibeg_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  exception_kind;
        logic [31:0] exception_addr;
        logic [1:0]  program_reason;
        logic [31:0] counter_one;
        logic [31:0] counter_two;
        logic        perf_irq_pending;
    } ibeg_out_t;

    // action codes
    localparam logic [2:0] ACT_NAP         = 3'd0;
    localparam logic [2:0] ACT_EXECUTED    = 3'd1;
    localparam logic [2:0] ACT_EXCEPTION   = 3'd2;
    localparam logic [2:0] ACT_FETCH_ABORT = 3'd3;
    localparam logic [2:0] ACT_HALT        = 3'd4;

    // exception kinds
    localparam logic [3:0] EXC_NONE    = 4'd0;
    localparam logic [3:0] EXC_SMI     = 4'd1;
    localparam logic [3:0] EXC_EXT     = 4'd2;
    localparam logic [3:0] EXC_DEC     = 4'd3;
    localparam logic [3:0] EXC_PERF    = 4'd4;
    localparam logic [3:0] EXC_IABR    = 4'd5;
    localparam logic [3:0] EXC_PROGRAM = 4'd6;
    localparam logic [3:0] EXC_FP_UNAV = 4'd7;
    localparam logic [3:0] EXC_VEC_UNAV = 4'd8;
    localparam logic [3:0] EXC_TRACE   = 4'd9;

    // program exception reasons
    localparam logic [1:0] PRG_NONE       = 2'd0;
    localparam logic [1:0] PRG_ILLEGAL    = 2'd1;
    localparam logic [1:0] PRG_PRIVILEGED = 2'd2;

    // instruction classes
    localparam logic [1:0] CLS_BRANCH = 2'd1;
    localparam logic [1:0] CLS_RFI    = 2'd2;

    // configuration register indexes
    localparam logic REG_IABR = 1'b0;
    localparam logic REG_PERF = 1'b1;

    // MSR bit positions
    localparam int MSR_EE  = 0;
    localparam int MSR_IR  = 1;
    localparam int MSR_PR  = 2;
    localparam int MSR_FP  = 3;
    localparam int MSR_VEC = 4;
    localparam int MSR_SE  = 5;
    localparam int MSR_BE  = 6;

    // irq_events bit positions
    localparam int EV_SMI = 0;
    localparam int EV_EXT = 1;
    localparam int EV_DEC = 2;
    localparam int EV_NAP = 3;

    // insn_gates bit positions
    localparam int GATE_UNIMPL = 0;
    localparam int GATE_SUPER  = 1;
    localparam int GATE_FP     = 2;
    localparam int GATE_VEC    = 3;

    // perf_control fields
    localparam int PERF_FREEZE    = 31;
    localparam int PERF_MASTER_EN = 26;
    localparam int PERF_ONE_EN    = 15;
    localparam int PERF_TWO_EN    = 14;
    localparam logic [6:0] SEL_INSN_A = 7'd1;
    localparam logic [6:0] SEL_INSN_B = 7'd2;

    localparam logic [31:0] IABR_ADDR_MASK = 32'hFFFF_FFFC;
    localparam logic [31:0] MSB_EDGE_VALUE = 32'h7FFF_FFFF;
    localparam logic [31:0] INSN_BYTES     = 32'd4;

endpackage

// ===== rtl/core/insn_boundary_exception_gate.sv =====
// ----------------------------------------------------------------------------
// insn_boundary_exception_gate: exception priority and perf counter gate
// Decides, per instruction boundary, nap, exception, fetch abort, halt or
// execute, and keeps the pending interrupts and two perf counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one beat per
//   instruction boundary. Output channel (out_valid/out_ready/out_data)
//   returns exactly one result beat for each input beat, in order.
//   Configuration is a plain write port (cfg_we/cfg_index/cfg_data):
//   index 0 writes the IABR word, index 1 writes perf control. Write only
//   while no beat is in flight.
//   Path: an accepted beat lands in the input stage; its result is
//   registered as that stage advances and shown on out_valid from then on.
//   Throughput: one beat per cycle unless the result side stalls. The
//   pending flags and counters are updated at the same edge that registers
//   the result, so the next beat in the input stage always sees them settled.
//   Stall: while out_valid is high and out_ready low, the result holds and
//   the input stage holds; in_ready drops only when both stages are full.
//   Reset: rst_n low clears both stages, the pending flags, the nap flag,
//   both counters and both configuration registers.
// ----------------------------------------------------------------------------
module insn_boundary_exception_gate
    import ibeg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ibeg_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ibeg_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [31:0] iabr_reg;
    logic [31:0] perf_ctl_reg;

    // architectural state
    logic        smi_pend_reg, smi_pend_next;
    logic        dec_pend_reg, dec_pend_next;
    logic        perf_pend_reg, perf_pend_next;
    logic        nap_reg, nap_next;
    logic [31:0] cnt_one_reg, cnt_one_next;
    logic [31:0] cnt_two_reg, cnt_two_next;

    // pipeline
    logic        s1_valid_reg;
    ibeg_in_t    s1_reg;
    logic        out_valid_reg;
    ibeg_out_t   out_reg, out_next;
    logic        advance;

    // The input stage moves on when the result register is free or drains now.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iabr_reg     <= '0;
            perf_ctl_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IABR: iabr_reg     <= cfg_data;
                REG_PERF: perf_ctl_reg <= cfg_data;
                default:  iabr_reg     <= iabr_reg;
            endcase
        end
    end

    // Input stage: take a beat whenever there is room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_reg <= in_data;
    end

    // Result stage and state update, both on advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            smi_pend_reg  <= 1'b0;
            dec_pend_reg  <= 1'b0;
            perf_pend_reg <= 1'b0;
            nap_reg       <= 1'b0;
            cnt_one_reg   <= '0;
            cnt_two_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                smi_pend_reg  <= smi_pend_next;
                dec_pend_reg  <= dec_pend_next;
                perf_pend_reg <= perf_pend_next;
                nap_reg       <= nap_next;
                cnt_one_reg   <= cnt_one_next;
                cnt_two_reg   <= cnt_two_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    // Boundary decision for the beat in the input stage.
    always_comb
    begin
        logic        ee;
        logic        ext_line;
        logic        smi_p;
        logic        dec_p;
        logic        nap_p;
        logic        perf_p;
        logic        wake;
        logic        iabr_hit;
        logic        cnt_run;
        logic [6:0]  sel_one;
        logic [6:0]  sel_two;
        logic        inc_one;
        logic        inc_two;
        logic        taken;
        logic [2:0]  act;
        logic [3:0]  kind;
        logic [31:0] eaddr;
        logic [1:0]  reason;
        logic        execute;

        ee       = s1_reg.msr_bits[MSR_EE];
        ext_line = s1_reg.irq_events[EV_EXT];

        // latch requests first
        smi_p  = smi_pend_reg | s1_reg.irq_events[EV_SMI];
        dec_p  = dec_pend_reg | s1_reg.irq_events[EV_DEC];
        nap_p  = nap_reg | s1_reg.irq_events[EV_NAP];
        perf_p = perf_pend_reg;
        wake   = ee && (smi_p || ext_line || dec_p || perf_p);

        iabr_hit = iabr_reg[1]
                && (((s1_reg.insn_addr ^ iabr_reg) & IABR_ADDR_MASK) == '0)
                && (iabr_reg[0] == s1_reg.msr_bits[MSR_IR]);

        act     = ACT_EXECUTED;
        kind    = EXC_NONE;
        eaddr   = '0;
        reason  = PRG_NONE;
        execute = 1'b0;

        priority if (nap_p && !wake)
        begin
            act = ACT_NAP;
        end
        else if (ee && smi_p)
        begin
            smi_p = 1'b0;
            act   = ACT_EXCEPTION;
            kind  = EXC_SMI;
            eaddr = s1_reg.insn_addr;
        end
        else if (ee && ext_line)
        begin
            act   = ACT_EXCEPTION;
            kind  = EXC_EXT;
            eaddr = s1_reg.insn_addr;
        end
        else if (ee && dec_p)
        begin
            dec_p = 1'b0;
            act   = ACT_EXCEPTION;
            kind  = EXC_DEC;
            eaddr = s1_reg.insn_addr;
        end
        else if (ee && perf_p)
        begin
            perf_p = 1'b0;
            act    = ACT_EXCEPTION;
            kind   = EXC_PERF;
            eaddr  = s1_reg.insn_addr;
        end
        else if (iabr_hit)
        begin
            act   = ACT_EXCEPTION;
            kind  = EXC_IABR;
            eaddr = s1_reg.insn_addr;
        end
        else if (s1_reg.fetch_fault)
        begin
            act = ACT_FETCH_ABORT;
        end
        else if (!s1_reg.insn_known || s1_reg.insn_gates[GATE_UNIMPL])
        begin
            act    = ACT_EXCEPTION;
            kind   = EXC_PROGRAM;
            eaddr  = s1_reg.insn_addr;
            reason = PRG_ILLEGAL;
        end
        else if (s1_reg.insn_gates[GATE_SUPER] && s1_reg.msr_bits[MSR_PR])
        begin
            act    = ACT_EXCEPTION;
            kind   = EXC_PROGRAM;
            eaddr  = s1_reg.insn_addr;
            reason = PRG_PRIVILEGED;
        end
        else if (s1_reg.insn_gates[GATE_FP] && !s1_reg.msr_bits[MSR_FP])
        begin
            act   = ACT_EXCEPTION;
            kind  = EXC_FP_UNAV;
            eaddr = s1_reg.insn_addr;
        end
        else if (s1_reg.insn_gates[GATE_VEC] && !s1_reg.msr_bits[MSR_VEC])
        begin
            act   = ACT_EXCEPTION;
            kind  = EXC_VEC_UNAV;
            eaddr = s1_reg.insn_addr;
        end
        else if (!s1_reg.handler_present)
        begin
            act = ACT_HALT;
        end
        else
        begin
            execute = 1'b1;
        end

        // a wake always clears the nap, even if nap was entered this beat
        nap_next = nap_p && !wake;

        // perf counters advance only on executed instructions
        cnt_run = (perf_ctl_reg != '0) && !perf_ctl_reg[PERF_FREEZE];
        sel_one = perf_ctl_reg[12:6];
        sel_two = {1'b0, perf_ctl_reg[5:0]};
        inc_one = execute && cnt_run && (sel_one == SEL_INSN_A || sel_one == SEL_INSN_B);
        inc_two = execute && cnt_run && (sel_two == SEL_INSN_A || sel_two == SEL_INSN_B);

        cnt_one_next = inc_one ? cnt_one_reg + 32'd1 : cnt_one_reg;
        cnt_two_next = inc_two ? cnt_two_reg + 32'd1 : cnt_two_reg;

        // MSB going 0 to 1 requests the perf interrupt when the master and counter enables are set
        if (perf_ctl_reg[PERF_MASTER_EN])
        begin
            if (inc_one && perf_ctl_reg[PERF_ONE_EN] && cnt_one_reg == MSB_EDGE_VALUE)
                perf_p = 1'b1;
            if (inc_two && perf_ctl_reg[PERF_TWO_EN] && cnt_two_reg == MSB_EDGE_VALUE)
                perf_p = 1'b1;
        end

        // single-step and taken-branch trace
        taken = (s1_reg.insn_class == CLS_BRANCH)
             && (s1_reg.next_addr != s1_reg.insn_addr + INSN_BYTES);
        if (execute && !s1_reg.handler_raised && s1_reg.insn_class != CLS_RFI
            && (s1_reg.msr_bits[MSR_SE] || (s1_reg.msr_bits[MSR_BE] && taken)))
        begin
            kind  = EXC_TRACE;
            eaddr = s1_reg.next_addr;
        end

        smi_pend_next  = smi_p;
        dec_pend_next  = dec_p;
        perf_pend_next = perf_p;

        out_next.action           = act;
        out_next.exception_kind   = kind;
        out_next.exception_addr   = eaddr;
        out_next.program_reason   = reason;
        out_next.counter_one      = cnt_one_next;
        out_next.counter_two      = cnt_two_next;
        out_next.perf_irq_pending = perf_p;
    end

endmodule

// ===== rtl/core/ibeg_checker.sv =====
// ----------------------------------------------------------------------------
// ibeg_checker: port-level checks for the instruction boundary gate
// Watches the result channel and the coding of result beats.
// ----------------------------------------------------------------------------
module ibeg_checker
    import ibeg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input ibeg_out_t out_data
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // nap, fetch abort and halt beats carry no exception
    a_quiet_actions: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == ACT_NAP || out_data.action == ACT_FETCH_ABORT
                      || out_data.action == ACT_HALT)
        |-> out_data.exception_kind == EXC_NONE && out_data.exception_addr == '0
            && out_data.program_reason == PRG_NONE)
        else $error("quiet action with exception fields set");

    // trace only follows an executed instruction
    a_trace_exec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.exception_kind == EXC_TRACE
        |-> out_data.action == ACT_EXECUTED)
        else $error("trace without execution");

    // a program reason only comes with a program exception
    a_reason_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.program_reason != PRG_NONE
        |-> out_data.exception_kind == EXC_PROGRAM && out_data.action == ACT_EXCEPTION)
        else $error("program reason without program exception");

endmodule

bind insn_boundary_exception_gate ibeg_checker u_ibeg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/ibeg_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ibeg_tb_pkg: scoreboard for the instruction boundary gate
// Keeps its own copy of the pending interrupts, nap flag, perf counters and
// both registers, predicts one result beat per boundary beat and compares
// arriving results against the oldest prediction.
// ----------------------------------------------------------------------------
package ibeg_tb_pkg;

    import ibeg_pkg::*;

    class boundary_scoreboard;

        logic [31:0] iabr_word;
        logic [31:0] perf_control;
        bit          smi_pending;
        bit          dec_pending;
        bit          perf_pending;
        bit          napping;
        logic [31:0] count_one;
        logic [31:0] count_two;

        ibeg_out_t   expected_outcomes[$];
        int          errors;
        int          beats;
        int          results;
        int          action_seen[5];
        int          kind_seen[10];

        function new();
            iabr_word    = '0;
            perf_control = '0;
            smi_pending  = 0;
            dec_pending  = 0;
            perf_pending = 0;
            napping      = 0;
            count_one    = '0;
            count_two    = '0;
            errors       = 0;
            beats        = 0;
            results      = 0;
            foreach (action_seen[i]) action_seen[i] = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void write_register(logic index, logic [31:0] value);
            if (index == REG_IABR)
                iabr_word = value;
            else
                perf_control = value;
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction

        function ibeg_out_t outcome(logic [2:0] act, logic [3:0] kind,
                                    logic [31:0] addr, logic [1:0] reason);
            ibeg_out_t r;
            r.action           = act;
            r.exception_kind   = kind;
            r.exception_addr   = addr;
            r.program_reason   = reason;
            r.counter_one      = count_one;
            r.counter_two      = count_two;
            r.perf_irq_pending = perf_pending;
            return r;
        endfunction

        // Raise the perf interrupt only on a 0-to-1 change of the MSB.
        function logic [31:0] bump(logic [31:0] old, int enable_bit);
            logic [31:0] next;
            next = old + 32'd1;
            if (!old[31] && next[31] && perf_control[PERF_MASTER_EN]
                && perf_control[enable_bit])
                perf_pending = 1;
            return next;
        endfunction

        function void advance_counters();
            logic [6:0] sel_one;
            logic [6:0] sel_two;
            if (perf_control == 32'd0 || perf_control[PERF_FREEZE])
                return;
            sel_one = perf_control[12:6];
            sel_two = {1'b0, perf_control[5:0]};
            if (sel_one == SEL_INSN_A || sel_one == SEL_INSN_B)
                count_one = bump(count_one, PERF_ONE_EN);
            if (sel_two == SEL_INSN_A || sel_two == SEL_INSN_B)
                count_two = bump(count_two, PERF_TWO_EN);
        endfunction

        function ibeg_out_t predict_boundary(ibeg_in_t b);
            bit         ee;
            bit         ext_line;
            bit         taken;
            logic [6:0] msr;
            msr      = b.msr_bits;
            ee       = msr[MSR_EE];
            ext_line = b.irq_events[EV_EXT];

            if (b.irq_events[EV_SMI]) smi_pending = 1;
            if (b.irq_events[EV_DEC]) dec_pending = 1;
            if (b.irq_events[EV_NAP]) napping = 1;

            if (napping) begin
                if (!(ee && (smi_pending || ext_line || dec_pending || perf_pending)))
                    return outcome(ACT_NAP, EXC_NONE, 32'd0, PRG_NONE);
                napping = 0;
            end

            if (ee) begin
                if (smi_pending) begin
                    smi_pending = 0;
                    return outcome(ACT_EXCEPTION, EXC_SMI, b.insn_addr, PRG_NONE);
                end
                if (ext_line)
                    return outcome(ACT_EXCEPTION, EXC_EXT, b.insn_addr, PRG_NONE);
                if (dec_pending) begin
                    dec_pending = 0;
                    return outcome(ACT_EXCEPTION, EXC_DEC, b.insn_addr, PRG_NONE);
                end
                if (perf_pending) begin
                    perf_pending = 0;
                    return outcome(ACT_EXCEPTION, EXC_PERF, b.insn_addr, PRG_NONE);
                end
            end

            if (iabr_word[1] && ((b.insn_addr ^ iabr_word) & IABR_ADDR_MASK) == 32'd0
                && iabr_word[0] == msr[MSR_IR])
                return outcome(ACT_EXCEPTION, EXC_IABR, b.insn_addr, PRG_NONE);

            if (b.fetch_fault)
                return outcome(ACT_FETCH_ABORT, EXC_NONE, 32'd0, PRG_NONE);

            if (!b.insn_known || b.insn_gates[GATE_UNIMPL])
                return outcome(ACT_EXCEPTION, EXC_PROGRAM, b.insn_addr, PRG_ILLEGAL);
            if (b.insn_gates[GATE_SUPER] && msr[MSR_PR])
                return outcome(ACT_EXCEPTION, EXC_PROGRAM, b.insn_addr, PRG_PRIVILEGED);
            if (b.insn_gates[GATE_FP] && !msr[MSR_FP])
                return outcome(ACT_EXCEPTION, EXC_FP_UNAV, b.insn_addr, PRG_NONE);
            if (b.insn_gates[GATE_VEC] && !msr[MSR_VEC])
                return outcome(ACT_EXCEPTION, EXC_VEC_UNAV, b.insn_addr, PRG_NONE);

            if (!b.handler_present)
                return outcome(ACT_HALT, EXC_NONE, 32'd0, PRG_NONE);

            advance_counters();

            taken = (b.insn_class == CLS_BRANCH)
                    && (b.next_addr != b.insn_addr + INSN_BYTES);
            if (!b.handler_raised && b.insn_class != CLS_RFI
                && (msr[MSR_SE] || (msr[MSR_BE] && taken)))
                return outcome(ACT_EXECUTED, EXC_TRACE, b.next_addr, PRG_NONE);

            return outcome(ACT_EXECUTED, EXC_NONE, 32'd0, PRG_NONE);
        endfunction

        function void note_boundary(ibeg_in_t b);
            beats++;
            expected_outcomes.push_back(predict_boundary(b));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %h, actual %h",
                             $time, name, want, got);
            end
        endfunction

        function void check_outcome(ibeg_out_t got);
            ibeg_out_t want;
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_outcomes.pop_front();
            results++;
            action_seen[want.action]++;
            kind_seen[want.exception_kind]++;
            check_field("action", 32'(want.action), 32'(got.action));
            check_field("exception_kind", 32'(want.exception_kind),
                        32'(got.exception_kind));
            check_field("exception_addr", want.exception_addr, got.exception_addr);
            check_field("program_reason", 32'(want.program_reason),
                        32'(got.program_reason));
            check_field("counter_one", want.counter_one, got.counter_one);
            check_field("counter_two", want.counter_two, got.counter_two);
            check_field("perf_irq_pending", 32'(want.perf_irq_pending),
                        32'(got.perf_irq_pending));
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: instruction boundary gate, directed and random checking
// Drives boundary beats through the valid/ready input with bursty timing,
// stalls the result channel on its own pattern, and checks every result beat
// field by field against a scoreboard that tracks pending interrupts, nap
// and the perf counters. Several register settings are visited, including
// both extremes of each register.
// ----------------------------------------------------------------------------
module testbench;

    import ibeg_pkg::*;
    import ibeg_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ibeg_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    ibeg_out_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    boundary_scoreboard book = new();

    // Word address that random beats aim at to hit the breakpoint.
    logic [31:0] iabr_hot;
    // Bumped by the stimulus to ask the receiver for a long hold-off.
    int          hold_requests;

    insn_boundary_exception_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Observe everything at the rising edge: register writes, accepted
    // boundary beats and accepted result beats. Inputs only move at the
    // falling edge, so the values seen here are the ones the block sampled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                book.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                book.note_boundary(in_data);
            if (out_valid && out_ready)
                book.check_outcome(out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Result side: pick a stall pattern, keep it for a random stretch, then
    // pick another. Mode 0 never stalls. A hold request drops ready for a
    // long count of cycles so the block fills up and pushes back on input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int mode_left;
        int served;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        served    = 0;
        hold_left = 0;
        tick      = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_requests != served)
            begin
                served    = hold_requests;
                hold_left = 64;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks. Each one changes inputs at the next falling edge after
    // it starts.
    // ------------------------------------------------------------------------

    // Offer one beat and hold it until the block takes it.
    task automatic send_boundary(input ibeg_in_t b);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] perf_word(bit freeze, bit master, bit en_one,
                                              bit en_two, logic [6:0] sel_one,
                                              logic [5:0] sel_two);
        logic [31:0] v;
        v                 = '0;
        v[PERF_FREEZE]    = freeze;
        v[PERF_MASTER_EN] = master;
        v[PERF_ONE_EN]    = en_one;
        v[PERF_TWO_EN]    = en_two;
        v[12:6]           = sel_one;
        v[5:0]            = sel_two;
        return v;
    endfunction

    // A clean instruction that executes with nothing pending.
    function automatic ibeg_in_t plain_insn(logic [31:0] addr);
        ibeg_in_t b;
        b                 = '0;
        b.insn_addr       = addr;
        b.insn_known      = 1'b1;
        b.handler_present = 1'b1;
        b.next_addr       = addr + INSN_BYTES;
        return b;
    endfunction

    // Mostly well-formed instructions with random content; the rest is noise.
    function automatic ibeg_in_t random_boundary();
        ibeg_in_t b;
        b = plain_insn($urandom() & IABR_ADDR_MASK);
        if ($urandom_range(0, 3) == 0)
            b.insn_addr[1:0] = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            b.insn_addr = iabr_hot | $urandom_range(0, 3);
        b.msr_bits = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 5) == 0)
            b.irq_events = 4'($urandom_range(1, 15));
        b.insn_class = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
            b.next_addr = $urandom();
        else
            b.next_addr = b.insn_addr + INSN_BYTES;
        if ($urandom_range(0, 99) < 15)
        begin
            // noise: every control field random
            b.irq_events      = 4'($urandom_range(0, 15));
            b.fetch_fault     = 1'($urandom_range(0, 1));
            b.insn_known      = 1'($urandom_range(0, 1));
            b.insn_gates      = 4'($urandom_range(0, 15));
            b.handler_present = 1'($urandom_range(0, 1));
            b.handler_raised  = 1'($urandom_range(0, 1));
        end
        else
        begin
            b.fetch_fault     = ($urandom_range(0, 19) == 0);
            b.insn_known      = ($urandom_range(0, 19) != 0);
            b.handler_present = ($urandom_range(0, 29) != 0);
            b.handler_raised  = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0)
                b.insn_gates = 4'($urandom_range(1, 15));
        end
        return b;
    endfunction

    // Bursts of back-to-back beats with random gaps, sometimes none.
    task automatic run_random(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                send_boundary(random_boundary());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_cycles(gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        ibeg_in_t    b;
        int          phase;
        logic [31:0] iabr_value;
        logic [31:0] perf_value;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_IABR;
        cfg_data      = '0;
        iabr_hot      = '0;
        hold_requests = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Breakpoint on 0x1000 in untranslated mode; both counters count.
        iabr_hot = 32'h0000_1000;
        write_register(REG_IABR, 32'h0000_1002);
        write_register(REG_PERF, perf_word(1'b0, 1'b1, 1'b1, 1'b1, SEL_INSN_A, 6'd2));

        // Directed: address extremes, every MSR bit set at once (single-step).
        b = plain_insn(32'h0000_0000);
        send_boundary(b);
        b = plain_insn(32'hFFFF_FFFF);
        b.msr_bits = 7'h7F;
        send_boundary(b);

        // Enter nap with EE clear, stay asleep, then wake on the external line.
        b = plain_insn(32'h0000_2000);
        b.irq_events[EV_NAP] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_2004);
        b.msr_bits[MSR_EE] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_2008);
        b.msr_bits[MSR_EE] = 1'b1;
        b.irq_events[EV_EXT] = 1'b1;
        send_boundary(b);

        // Latch SMI with EE clear, then SMI beats decrementer, then decrementer.
        b = plain_insn(32'h0000_3000);
        b.irq_events[EV_SMI] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_3004);
        b.msr_bits[MSR_EE] = 1'b1;
        b.irq_events[EV_DEC] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_3008);
        b.msr_bits[MSR_EE] = 1'b1;
        send_boundary(b);

        // Nap and wake in the same beat.
        b = plain_insn(32'h0000_300C);
        b.msr_bits[MSR_EE] = 1'b1;
        b.irq_events[EV_NAP] = 1'b1;
        b.irq_events[EV_SMI] = 1'b1;
        send_boundary(b);

        // Breakpoint: low address bits ignored; wrong translation mode misses.
        b = plain_insn(32'h0000_1003);
        send_boundary(b);
        b = plain_insn(32'h0000_1000);
        b.msr_bits[MSR_IR] = 1'b1;
        send_boundary(b);

        // Fetch fault, unknown word with gates, each gate trapping or passing.
        b = plain_insn(32'h0000_4000);
        b.fetch_fault = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_4004);
        b.insn_known = 1'b0;
        b.insn_gates = 4'hF;
        send_boundary(b);
        b = plain_insn(32'h0000_4008);
        b.insn_gates[GATE_UNIMPL] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_400C);
        b.insn_gates[GATE_SUPER] = 1'b1;
        b.msr_bits[MSR_PR] = 1'b1;
        send_boundary(b);
        b.msr_bits[MSR_PR] = 1'b0;
        send_boundary(b);
        b = plain_insn(32'h0000_4010);
        b.insn_gates[GATE_FP] = 1'b1;
        send_boundary(b);
        b.msr_bits[MSR_FP] = 1'b1;
        send_boundary(b);
        b = plain_insn(32'h0000_4014);
        b.insn_gates[GATE_VEC] = 1'b1;
        send_boundary(b);

        // Missing handler halts; a handler that raised is never traced.
        b = plain_insn(32'h0000_5000);
        b.handler_present = 1'b0;
        send_boundary(b);
        b = plain_insn(32'h0000_5004);
        b.msr_bits[MSR_SE] = 1'b1;
        b.handler_raised = 1'b1;
        send_boundary(b);

        // Branch trace: taken, not taken across the address wrap, rfi, class 3.
        b = plain_insn(32'h0000_6000);
        b.msr_bits[MSR_BE] = 1'b1;
        b.insn_class = CLS_BRANCH;
        b.next_addr = 32'hFFFF_FFFF;
        send_boundary(b);
        b = plain_insn(32'hFFFF_FFFC);
        b.msr_bits[MSR_BE] = 1'b1;
        b.insn_class = CLS_BRANCH;
        send_boundary(b);
        b = plain_insn(32'h0000_6004);
        b.msr_bits[MSR_SE] = 1'b1;
        b.insn_class = CLS_RFI;
        send_boundary(b);
        b.insn_class = 2'd3;
        send_boundary(b);

        // Random phases, each under its own register setting. The counters
        // can never reach their MSB in a run this short, so the perf
        // interrupt stays out of reach.
        for (phase = 0; phase < 7; phase++)
        begin
            wait_all_results();
            case (phase)
                0:
                begin
                    iabr_value = 32'h0000_0000;
                    perf_value = 32'h0000_0000;
                end
                1:
                begin
                    iabr_value = 32'hFFFF_FFFF;
                    perf_value = 32'hFFFF_FFFF;
                end
                2:
                begin
                    iabr_value = $urandom() | 32'h2;
                    perf_value = perf_word(1'b0, 1'b1, 1'b1, 1'b1, SEL_INSN_A, 6'd2);
                end
                3:
                begin
                    iabr_value = $urandom() | 32'h2;
                    perf_value = perf_word(1'b0, 1'b0, 1'b1, 1'b0, SEL_INSN_B, 6'd7);
                end
                4:
                begin
                    iabr_value = $urandom();
                    perf_value = $urandom() & 32'h7FFF_FFFF;
                end
                5:
                begin
                    iabr_value = $urandom();
                    perf_value = $urandom();
                end
                default:
                begin
                    iabr_value = ($urandom() & IABR_ADDR_MASK) | 32'h2;
                    perf_value = perf_word(1'b0, 1'b1, 1'b0, 1'b1, SEL_INSN_A, 6'd1);
                end
            endcase
            iabr_hot = iabr_value & IABR_ADDR_MASK;
            write_register(REG_IABR, iabr_value);
            write_register(REG_PERF, perf_value);

            // Stall the result side for a long stretch while beats keep coming.
            if (phase == 2)
                hold_requests++;

            if (phase == 4)
            begin
                // Pause mid-phase until the block has answered everything.
                run_random(50);
                wait_all_results();
                run_random(50);
            end
            else
                run_random(100);
        end

        // Drain, then keep the clock running so any stray beat would show.
        wait_all_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d of %0d beats: %0d napping, %0d executed, %0d exceptions,",
                 book.results, book.beats, book.action_seen[ACT_NAP],
                 book.action_seen[ACT_EXECUTED], book.action_seen[ACT_EXCEPTION]);
        $display("%0d fetch aborts, %0d halts, %0d traces, %0d breakpoints, %0d SMI/ext/dec.",
                 book.action_seen[ACT_FETCH_ABORT], book.action_seen[ACT_HALT],
                 book.kind_seen[EXC_TRACE], book.kind_seen[EXC_IABR],
                 book.kind_seen[EXC_SMI] + book.kind_seen[EXC_EXT]
                 + book.kind_seen[EXC_DEC]);
        if (book.errors == 0 && book.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #2000000;
        $display("Timed out with %0d results still expected", book.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
